// ----- rtl/bezier_thick_strip_tessellator_core_assert.svh -----
// Assertion helpers for the stroke tessellator.
`ifndef BEZIER_THICK_STRIP_TESSELLATOR_CORE_ASSERT_SVH
`define BEZIER_THICK_STRIP_TESSELLATOR_CORE_ASSERT_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define BZST_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bzst assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define BZST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bzst assertion failed");
`else
`define BZST_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BZST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/bzst_pkg.sv -----
package bzst_pkg;

    localparam int COORD_W          = 16;
    localparam int WIDTH_W          = 12;
    localparam int SAMPLE_COUNT_DEF = 20;
    localparam int T_W              = 17;
    localparam logic [T_W-1:0] T_ONE  = 17'd65536;
    localparam logic [T_W-1:0] T_STEP = 17'd655;

    localparam int RAD_W  = 62;
    localparam int ROOT_W = 31;
    localparam int PROD_W = 42;
    localparam int NUM_W  = 43;
    localparam int DEN_W  = 32;
    localparam int QUO_W  = 12;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl_x;
        logic signed [COORD_W-1:0] ctrl_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic        [WIDTH_W-1:0] stroke_width;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] upper_x;
        logic signed [COORD_W-1:0] upper_y;
        logic signed [COORD_W-1:0] lower_x;
        logic signed [COORD_W-1:0] lower_y;
        logic                      last_sample;
    } t_out;

    // Per-sample data that rides alongside the root and quotient pipes.
    typedef struct packed {
        logic signed [COORD_W:0] bx;
        logic signed [COORD_W:0] by;
        logic                    neg_dx;
        logic                    neg_dy;
        logic                    short_chord;
        logic                    last;
    } t_side;

    typedef struct packed {
        t_side              core;
        logic [PROD_W-1:0]  na;
        logic [PROD_W-1:0]  nb;
    } t_sqrt_side;

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [COORD_W+1:0] v);
        logic signed [COORD_W+1:0] hi;
        logic signed [COORD_W+1:0] lo;
        hi = 18'sd32767;
        lo = -18'sd32768;
        if (v > hi) begin
            return 16'sh7fff;
        end else if (v < lo) begin
            return 16'sh8000;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ----- rtl/bzst_sqrt.sv -----
module bzst_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [61:0]       i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [30:0]       o_root,
    output logic [SIDE_W-1:0] o_side
);
    import bzst_pkg::*;

    localparam int STAGES = ROOT_W;

    logic [STAGES:1]    r_v;
    logic [RAD_W-1:0]   r_x    [1:STAGES];
    logic [RAD_W-1:0]   r_res  [1:STAGES];
    logic [SIDE_W-1:0]  r_side [1:STAGES];

    // One root bit per stage, restoring digit recurrence.
    for (genvar k = 0; k < STAGES; k++) begin : g_st
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
        logic              v_in;
        logic [RAD_W-1:0]  x_in;
        logic [RAD_W-1:0]  res_in;
        logic [SIDE_W-1:0] side_in;
        logic [RAD_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = i_rad;
            assign res_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k];
            assign x_in    = r_x[k];
            assign res_in  = r_res[k];
            assign side_in = r_side[k];
        end

        assign trial = res_in + BIT;
        assign ge    = (x_in >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= ge ? x_in - trial : x_in;
                r_res[k+1]  <= ge ? (res_in >> 1) + BIT : res_in >> 1;
                r_side[k+1] <= side_in;
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_root  = r_res[STAGES][ROOT_W-1:0];
    assign o_side  = r_side[STAGES];

endmodule

// ----- rtl/bzst_div.sv -----
module bzst_div #(
    parameter int SIDE_W = 1,
    parameter int NUM_W  = bzst_pkg::NUM_W,
    parameter int DEN_W  = bzst_pkg::DEN_W,
    parameter int Q_W    = bzst_pkg::QUO_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num_a,
    input  logic [NUM_W-1:0]  i_num_b,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo_a,
    output logic [Q_W-1:0]    o_quo_b,
    output logic [SIDE_W-1:0] o_side
);
    import bzst_pkg::*;

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [Q_W:1]       r_v;
    logic [NUM_W-1:0]   r_na   [1:Q_W];
    logic [NUM_W-1:0]   r_nb   [1:Q_W];
    logic [DEN_W-1:0]   r_den  [1:Q_W];
    logic [Q_W-1:0]     r_qa   [1:Q_W];
    logic [Q_W-1:0]     r_qb   [1:Q_W];
    logic [SIDE_W-1:0]  r_side [1:Q_W];

    // Two numerators share one divisor; one quotient bit per stage, MSB first.
    for (genvar k = 0; k < Q_W; k++) begin : g_st
        localparam int SH = Q_W - 1 - k;
        logic              v_in;
        logic [NUM_W-1:0]  na_in;
        logic [NUM_W-1:0]  nb_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    qa_in;
        logic [Q_W-1:0]    qb_in;
        logic [SIDE_W-1:0] side_in;
        logic [CW-1:0]     shifted;
        logic [CW-1:0]     diff_a;
        logic [CW-1:0]     diff_b;
        logic              ge_a;
        logic              ge_b;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign na_in   = i_num_a;
            assign nb_in   = i_num_b;
            assign den_in  = i_den;
            assign qa_in   = '0;
            assign qb_in   = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k];
            assign na_in   = r_na[k];
            assign nb_in   = r_nb[k];
            assign den_in  = r_den[k];
            assign qa_in   = r_qa[k];
            assign qb_in   = r_qb[k];
            assign side_in = r_side[k];
        end

        assign shifted = CW'(den_in) << SH;
        assign ge_a    = (CW'(na_in) >= shifted);
        assign ge_b    = (CW'(nb_in) >= shifted);
        assign diff_a  = CW'(na_in) - shifted;
        assign diff_b  = CW'(nb_in) - shifted;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_na[k+1]   <= ge_a ? diff_a[NUM_W-1:0] : na_in;
                r_nb[k+1]   <= ge_b ? diff_b[NUM_W-1:0] : nb_in;
                r_qa[k+1]   <= qa_in | (Q_W'(ge_a) << SH);
                r_qb[k+1]   <= qb_in | (Q_W'(ge_b) << SH);
                r_den[k+1]  <= den_in;
                r_side[k+1] <= side_in;
            end
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_quo_a = r_qa[Q_W];
    assign o_quo_b = r_qb[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

// ----- rtl/bezier_thick_strip_tessellator_core.sv -----
// Quadratic Bezier stroke tessellator. Each accepted word holds three control points and a
// stroke width (Q12.4 / Q8.4); the core returns SAMPLE_COUNT words, one per parameter step,
// each with the upper and lower strip vertex and a last flag on the final one. A new curve
// can be accepted while the last sample of the one before is issued; one vertex pair leaves
// per cycle unless the output stalls, a rate set by the sample sequencer feeding the pipeline.
// The longest parts of the pipeline are the 31-stage square-root pipe and the 12-stage
// divider. Any stall on the output freezes the whole pipeline.
`include "bezier_thick_strip_tessellator_core_assert.svh"

module bezier_thick_strip_tessellator_core #(
    parameter int SAMPLE_COUNT = bzst_pkg::SAMPLE_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bzst_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output bzst_pkg::t_out o_data
);
    import bzst_pkg::*;

    localparam int DEN      = (SAMPLE_COUNT - 1 < 1) ? 1 : SAMPLE_COUNT - 1;
    localparam int LAST_IDX = SAMPLE_COUNT - 1;
    localparam int IDXW     = (SAMPLE_COUNT > 2) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int RW       = $clog2(2 * DEN) + 1;
    localparam int STEP_Q   = 65536 / DEN;
    localparam int STEP_R   = 65536 % DEN;
    localparam int MAG_W    = 50;

    // ---------------- sample sequencer ----------------
    logic            r_busy;
    logic [IDXW-1:0] r_idx;
    logic [T_W-1:0]  r_q;
    logic [RW-1:0]   r_r;
    t_in             r_in;
    logic            en;
    logic            acc;
    logic            gen_last;
    logic [RW-1:0]   n_r;
    logic [T_W-1:0]  t1;
    logic [T_W-1:0]  t2;

    assign en       = !o_valid || i_ready;
    assign gen_last = (r_idx == IDXW'(LAST_IDX));
    assign o_ready  = !r_busy || (en && gen_last);
    assign acc      = i_valid && o_ready;
    assign n_r      = r_r + RW'(STEP_R);
    assign t1       = (r_q < T_STEP) ? '0 : r_q - T_STEP;
    assign t2       = (r_q > T_ONE - T_STEP) ? T_ONE : r_q + T_STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (acc) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (en && r_busy) begin
            if (gen_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // t = round(i * 1.0 / DEN), kept as quotient and remainder
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_in <= i_data;
            r_q  <= '0;
            r_r  <= RW'(DEN / 2);
        end else if (en && r_busy) begin
            if (n_r >= RW'(DEN)) begin
                r_r <= n_r - RW'(DEN);
                r_q <= r_q + T_W'(STEP_Q + 1);
            end else begin
                r_r <= n_r;
                r_q <= r_q + T_W'(STEP_Q);
            end
        end
    end

    // ---------------- pipeline registers ----------------
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v, r11_v;

    logic [T_W-1:0]  r1_t [0:2];
    t_in             r1_p;
    logic            r1_last;

    logic [32:0]     r2_a [0:2];
    logic [32:0]     r2_b [0:2];
    logic [32:0]     r2_c [0:2];
    t_in             r2_p;
    logic            r2_last;

    logic [32:0]        r3_a, r3_b, r3_c;
    logic signed [33:0] r3_da, r3_db, r3_dc;
    t_in                r3_p;
    logic               r3_last;

    logic signed [49:0] r4_wx [0:2];
    logic signed [49:0] r4_wy [0:2];
    logic signed [49:0] r4_dx [0:2];
    logic signed [49:0] r4_dy [0:2];
    logic [WIDTH_W-1:0] r4_w;
    logic               r4_last;

    logic signed [50:0] r5_wx, r5_wy, r5_dx, r5_dy;
    logic [WIDTH_W-1:0] r5_w;
    logic               r5_last;

    t_side              r6_side;
    logic [MAG_W-1:0]   r6_ax, r6_ay;
    logic [WIDTH_W-1:0] r6_w;

    t_side              r7_side;
    logic [MAG_W-1:0]   r7_ax, r7_ay;
    logic [5:0]         r7_s;
    logic [WIDTH_W-1:0] r7_w;

    t_side              r8_side;
    logic [29:0]        r8_ax, r8_ay;
    logic [WIDTH_W-1:0] r8_w;

    t_side              r9_side;
    logic [59:0]        r9_sqx, r9_sqy;
    logic [PROD_W-1:0]  r9_na, r9_nb;

    t_sqrt_side         r10_side;
    logic [RAD_W-1:0]   r10_rad;

    t_side              r11_side;
    logic [NUM_W-1:0]   r11_na, r11_nb;
    logic [DEN_W-1:0]   r11_den;

    logic               r_out_v;
    t_out               r_out;

    // ---------------- stage logic ----------------
    logic signed [50:0] vx, vy, ndx, ndy;
    logic [MAG_W-1:0]   ax, ay, mag_or;
    logic [5:0]         hi_bit, shift;
    logic [MAG_W-1:0]   sh_ax, sh_ay;

    assign vx  = r5_wx + 51'sh8000_0000;
    assign vy  = r5_wy + 51'sh8000_0000;
    assign ndx = -r5_dx;
    assign ndy = -r5_dy;
    assign ax  = r5_dx[50] ? ndx[MAG_W-1:0] : r5_dx[MAG_W-1:0];
    assign ay  = r5_dy[50] ? ndy[MAG_W-1:0] : r5_dy[MAG_W-1:0];

    // leading one of the larger magnitude
    assign mag_or = r6_ax | r6_ay;
    always_comb begin
        hi_bit = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (mag_or[k]) begin
                hi_bit = 6'(k);
            end
        end
        shift = (hi_bit >= 6'd30) ? hi_bit - 6'd29 : 6'd0;
    end

    assign sh_ax = r7_ax >> r7_s;
    assign sh_ay = r7_ay >> r7_s;

    function automatic logic [32:0] coef_a(input logic [T_W-1:0] t);
        logic [T_W-1:0] u;
        u = T_ONE - t;
        return 33'(u) * 33'(u);
    endfunction

    function automatic logic [32:0] coef_b(input logic [T_W-1:0] t);
        logic [T_W-1:0] u;
        u = T_ONE - t;
        return (33'(u) * 33'(t)) << 1;
    endfunction

    function automatic logic [32:0] coef_c(input logic [T_W-1:0] t);
        return 33'(t) * 33'(t);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
        end else if (en) begin
            r1_v  <= r_busy;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: parameters of the sample and both chord ends
            r1_t[0] <= r_q;
            r1_t[1] <= t1;
            r1_t[2] <= t2;
            r1_p    <= r_in;
            r1_last <= gen_last;

            // stage 2: Bernstein weights
            for (int j = 0; j < 3; j++) begin
                r2_a[j] <= coef_a(r1_t[j]);
                r2_b[j] <= coef_b(r1_t[j]);
                r2_c[j] <= coef_c(r1_t[j]);
            end
            r2_p    <= r1_p;
            r2_last <= r1_last;

            // stage 3: chord weights as differences
            r3_a    <= r2_a[0];
            r3_b    <= r2_b[0];
            r3_c    <= r2_c[0];
            r3_da   <= $signed({1'b0, r2_a[2]}) - $signed({1'b0, r2_a[1]});
            r3_db   <= $signed({1'b0, r2_b[2]}) - $signed({1'b0, r2_b[1]});
            r3_dc   <= $signed({1'b0, r2_c[2]}) - $signed({1'b0, r2_c[1]});
            r3_p    <= r2_p;
            r3_last <= r2_last;

            // stage 4: weight times control point
            r4_wx[0] <= $signed({1'b0, r3_a}) * r3_p.start_x;
            r4_wx[1] <= $signed({1'b0, r3_b}) * r3_p.ctrl_x;
            r4_wx[2] <= $signed({1'b0, r3_c}) * r3_p.end_x;
            r4_wy[0] <= $signed({1'b0, r3_a}) * r3_p.start_y;
            r4_wy[1] <= $signed({1'b0, r3_b}) * r3_p.ctrl_y;
            r4_wy[2] <= $signed({1'b0, r3_c}) * r3_p.end_y;
            r4_dx[0] <= r3_da * r3_p.start_x;
            r4_dx[1] <= r3_db * r3_p.ctrl_x;
            r4_dx[2] <= r3_dc * r3_p.end_x;
            r4_dy[0] <= r3_da * r3_p.start_y;
            r4_dy[1] <= r3_db * r3_p.ctrl_y;
            r4_dy[2] <= r3_dc * r3_p.end_y;
            r4_w     <= r3_p.stroke_width;
            r4_last  <= r3_last;

            // stage 5: sums
            r5_wx   <= r4_wx[0] + r4_wx[1] + r4_wx[2];
            r5_wy   <= r4_wy[0] + r4_wy[1] + r4_wy[2];
            r5_dx   <= r4_dx[0] + r4_dx[1] + r4_dx[2];
            r5_dy   <= r4_dy[0] + r4_dy[1] + r4_dy[2];
            r5_w    <= r4_w;
            r5_last <= r4_last;

            // stage 6: round the curve point, take chord magnitudes
            r6_side.bx          <= vx[48:32];
            r6_side.by          <= vy[48:32];
            r6_side.neg_dx      <= r5_dx[50];
            r6_side.neg_dy      <= r5_dy[50];
            r6_side.short_chord <= (ax[MAG_W-1:16] == '0) && (ay[MAG_W-1:16] == '0);
            r6_side.last        <= r5_last;
            r6_ax               <= ax;
            r6_ay               <= ay;
            r6_w                <= r5_w;

            // stage 7: normalising shift count
            r7_side <= r6_side;
            r7_ax   <= r6_ax;
            r7_ay   <= r6_ay;
            r7_s    <= shift;
            r7_w    <= r6_w;

            // stage 8: apply shift
            r8_side <= r7_side;
            r8_ax   <= sh_ax[29:0];
            r8_ay   <= sh_ay[29:0];
            r8_w    <= r7_w;

            // stage 9: squares and width products
            r9_side <= r8_side;
            r9_sqx  <= r8_ax * r8_ax;
            r9_sqy  <= r8_ay * r8_ay;
            r9_na   <= r8_ay * r8_w;
            r9_nb   <= r8_ax * r8_w;

            // stage 10: radicand
            r10_rad       <= RAD_W'(r9_sqx) + RAD_W'(r9_sqy);
            r10_side.core <= r9_side;
            r10_side.na   <= r9_na;
            r10_side.nb   <= r9_nb;
        end
    end

    // ---------------- square root ----------------
    logic               sq_v;
    logic [ROOT_W-1:0]  sq_root;
    t_sqrt_side         sq_side;

    bzst_sqrt #(
        .SIDE_W ($bits(t_sqrt_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r10_v),
        .i_rad   (r10_rad),
        .i_side  (r10_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage 11: rounding numerators and doubled length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (en) begin
            r11_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_side <= sq_side.core;
            r11_na   <= NUM_W'(sq_side.na) + NUM_W'(sq_root);
            r11_nb   <= NUM_W'(sq_side.nb) + NUM_W'(sq_root);
            r11_den  <= {sq_root, 1'b0};
        end
    end

    // ---------------- divider ----------------
    logic              dv_v;
    logic [QUO_W-1:0]  dv_ox, dv_oy;
    t_side             dv_side;

    bzst_div #(
        .SIDE_W ($bits(t_side)),
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .Q_W    (QUO_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r11_v),
        .i_num_a (r11_na),
        .i_num_b (r11_nb),
        .i_den   (r11_den),
        .i_side  (r11_side),
        .o_valid (dv_v),
        .o_quo_a (dv_ox),
        .o_quo_b (dv_oy),
        .o_side  (dv_side)
    );

    // ---------------- output word ----------------
    logic signed [QUO_W+1:0]   offx, offy;
    logic signed [COORD_W+1:0] ux, uy, lx, ly;

    always_comb begin
        offx = '0;
        offy = '0;
        if (!dv_side.short_chord) begin
            offx = dv_side.neg_dy ? $signed({2'b00, dv_ox}) : -$signed({2'b00, dv_ox});
            offy = dv_side.neg_dx ? -$signed({2'b00, dv_oy}) : $signed({2'b00, dv_oy});
        end
        ux = dv_side.bx + offx;
        uy = dv_side.by + offy;
        lx = dv_side.bx - offx;
        ly = dv_side.by - offy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.upper_x     <= sat16(ux);
            r_out.upper_y     <= sat16(uy);
            r_out.lower_x     <= sat16(lx);
            r_out.lower_y     <= sat16(ly);
            r_out.last_sample <= dv_side.last;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // ---------------- checks ----------------
    `BZST_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, acc, r_busy && (r_idx == '0))
    `BZST_ASSERT_NEXT(a_last_tagged, i_clk, i_rst_n, en && r_busy && gen_last, r1_v && r1_last)
    `BZST_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !en && r_busy, $stable(r1_v) && $stable(r_idx))
    `BZST_ASSERT_SAME(a_last_at_one, i_clk, i_rst_n, r1_v && r1_last, r1_t[0] == T_ONE)

endmodule
